/* design/uppc_pkg.sv */
// Shared types, register map and reset constants for the UPS power-path controller.
package uppc_pkg;

    // Width of every ADC sample and every voltage threshold.
    localparam int SAMPLE_BITS = 10;
    localparam int BEEP_BITS   = 6;
    localparam int BLINK_BITS  = 8;
    localparam int DRIVE_BITS  = 6;

    // APB register map: register index sits at paddr[4:2].
    localparam int PADDR_BITS  = 5;
    localparam int PDATA_BITS  = 32;
    localparam int REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_OVP_LEVEL    = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_EXT_HIGH     = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_EXT_LOW      = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_BAT_HIGH     = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_BAT_LOW      = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_BEEP_LENGTH  = 3'd5;

    // Reset values of the thresholds and the beep length.
    localparam logic [SAMPLE_BITS-1:0] RST_OVP_LEVEL    = SAMPLE_BITS'(900);
    localparam logic [SAMPLE_BITS-1:0] RST_EXT_HIGH     = SAMPLE_BITS'(820);
    localparam logic [SAMPLE_BITS-1:0] RST_EXT_LOW      = SAMPLE_BITS'(755);
    localparam logic [SAMPLE_BITS-1:0] RST_BAT_HIGH     = SAMPLE_BITS'(755);
    localparam logic [SAMPLE_BITS-1:0] RST_BAT_LOW      = SAMPLE_BITS'(692);
    localparam logic [BEEP_BITS-1:0]   RST_BEEP_LENGTH  = BEEP_BITS'(50);

    // Over-voltage blink counter limits.
    localparam logic [BLINK_BITS-1:0] BLINK_ON_START = BLINK_BITS'(1);
    localparam logic [BLINK_BITS-1:0] BLINK_OFF_FROM = BLINK_BITS'(100);
    localparam logic [BLINK_BITS-1:0] BLINK_WRAP     = BLINK_BITS'(200);

    // Bit positions in the drive latch.
    localparam int D_EXT   = 0;
    localparam int D_BAT   = 1;
    localparam int D_GREEN = 2;
    localparam int D_RED   = 3;
    localparam int D_BLUE  = 4;
    localparam int D_BUZZ  = 5;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] ext_sample;
        logic [SAMPLE_BITS-1:0] bat_sample;
        logic [SAMPLE_BITS-1:0] bat_recheck;
    } in_item_t;

    typedef struct packed {
        logic ext_relay;
        logic bat_relay;
        logic green_lamp;
        logic red_led;
        logic blue_lamp;
        logic buzzer_on;
        logic unmount_request;
        logic shutdown_request;
        logic ovp_flag;
    } out_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] ovp_level;
        logic [SAMPLE_BITS-1:0] ext_high_level;
        logic [SAMPLE_BITS-1:0] ext_low_level;
        logic [SAMPLE_BITS-1:0] bat_high_level;
        logic [SAMPLE_BITS-1:0] bat_low_level;
        logic [BEEP_BITS-1:0]   beep_length;
    } cfg_t;

    typedef struct packed {
        logic                  armed;
        logic [BLINK_BITS-1:0] ovp_blink_count;
        logic [BEEP_BITS-1:0]  beep_countdown;
        logic                  beep_done;
        logic [DRIVE_BITS-1:0] drive_latch;
    } ctrl_state_t;

    // Set the five relay and LED drives, keeping the buzzer as it is.
    function automatic logic [DRIVE_BITS-1:0] drive5(
        input logic [DRIVE_BITS-1:0] d,
        input logic e,
        input logic b,
        input logic g,
        input logic r,
        input logic bl
    );
        return {d[D_BUZZ], bl, r, g, b, e};
    endfunction

endpackage

/* design/uppc_rules.sv */
// Rule evaluation for one control tick: next controller state and the result item.
module uppc_rules (
    input  uppc_pkg::in_item_t    item,
    input  uppc_pkg::cfg_t        cfg,
    input  uppc_pkg::ctrl_state_t cur,
    output uppc_pkg::ctrl_state_t nxt,
    output uppc_pkg::out_item_t   result
);

    logic bhi, bmid, blo, ehi, elo, emid, ovp;
    logic                            armed;
    logic                            shut;
    logic                            done;
    logic [uppc_pkg::BLINK_BITS-1:0] blink;
    logic [uppc_pkg::BEEP_BITS-1:0]  cnt;
    logic [uppc_pkg::DRIVE_BITS-1:0] d;

    // Band decode of the battery and external samples; equal values match no band.
    assign bhi  = item.bat_sample > cfg.bat_high_level;
    assign bmid = (item.bat_sample > cfg.bat_low_level) &&
                  (item.bat_sample < cfg.bat_high_level);
    assign blo  = item.bat_sample < cfg.bat_low_level;
    assign ehi  = item.ext_sample > cfg.ext_high_level;
    assign elo  = item.ext_sample < cfg.ext_low_level;
    assign emid = (item.ext_sample > cfg.ext_low_level) &&
                  (item.ext_sample < cfg.ext_high_level);
    assign ovp  = item.ext_sample > cfg.ovp_level;

    // Rule groups in priority order; later groups overwrite earlier drives.
    always_comb begin
        armed = cur.armed;
        blink = cur.ovp_blink_count;
        cnt   = cur.beep_countdown;
        done  = cur.beep_done;
        d     = cur.drive_latch;
        shut  = 1'b0;

        // Over-voltage cutoff and green blink.
        if (ovp) begin
            d[uppc_pkg::D_EXT] = 1'b0;
            blink = blink + uppc_pkg::BLINK_BITS'(1);
            if (blink > uppc_pkg::BLINK_ON_START && blink < uppc_pkg::BLINK_OFF_FROM) begin
                d[uppc_pkg::D_GREEN] = 1'b1;
            end else if (blink >= uppc_pkg::BLINK_OFF_FROM) begin
                d[uppc_pkg::D_GREEN] = 1'b0;
            end
        end
        if (blink == uppc_pkg::BLINK_WRAP) begin
            blink = '0;
        end

        // External high or over-voltage.
        if (ehi && bhi && !ovp) begin
            armed = 1'b1;
            d = uppc_pkg::drive5(d, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        end else if (ehi && bmid && !ovp) begin
            armed = 1'b1;
            d = uppc_pkg::drive5(d, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        end else if (ehi && blo && !ovp) begin
            armed = 1'b1;
            d = uppc_pkg::drive5(d, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        end else if (bhi && ovp) begin
            armed = 1'b1;
            d[uppc_pkg::D_BAT]  = 1'b1;
            d[uppc_pkg::D_RED]  = 1'b0;
            d[uppc_pkg::D_BLUE] = 1'b0;
        end else if (bmid && ovp) begin
            armed = 1'b1;
            d[uppc_pkg::D_BAT]  = 1'b1;
            d[uppc_pkg::D_RED]  = 1'b0;
            d[uppc_pkg::D_BLUE] = 1'b1;
        end else if (blo && ovp) begin
            d[uppc_pkg::D_RED]  = 1'b1;
            d[uppc_pkg::D_BLUE] = 1'b0;
            if (armed) begin
                d     = '0;
                armed = 1'b0;
                shut  = 1'b1;
            end
        end

        // External mid band.
        if (emid && (bhi || bmid)) begin
            armed = 1'b1;
            d = uppc_pkg::drive5(d, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        end else if (emid && blo) begin
            armed = 1'b1;
            d = uppc_pkg::drive5(d, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        end

        // External low while disarmed.
        if (elo && !armed) begin
            if (bhi) begin
                armed = 1'b1;
                d = uppc_pkg::drive5(d, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
            end else if (bmid) begin
                d = uppc_pkg::drive5(d, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
            end else if (blo) begin
                d = uppc_pkg::drive5(d, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            end
        end

        // One-shot mains-loss beep.
        if (elo && (item.bat_sample > cfg.bat_low_level) && !done) begin
            if (cnt == cfg.beep_length) begin
                d[uppc_pkg::D_BUZZ] = 1'b1;
            end
            if (cnt == '0) begin
                d[uppc_pkg::D_BUZZ] = 1'b0;
                cnt  = cfg.beep_length;
                done = 1'b1;
            end else begin
                cnt = cnt - uppc_pkg::BEEP_BITS'(1);
            end
        end else if (ehi) begin
            done = 1'b0;
            d[uppc_pkg::D_BUZZ] = 1'b0;
        end

        // External low while armed; a confirmed low battery shuts down.
        if (elo && armed) begin
            if (bhi) begin
                d = uppc_pkg::drive5(d, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
            end else if (bmid) begin
                d = uppc_pkg::drive5(d, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
            end else if (blo) begin
                if (item.bat_recheck < cfg.bat_low_level) begin
                    d     = '0;
                    armed = 1'b0;
                    shut  = 1'b1;
                end
            end
        end
    end

    // Pack the next state and the result item.
    always_comb begin
        nxt.armed           = armed;
        nxt.ovp_blink_count = blink;
        nxt.beep_countdown  = cnt;
        nxt.beep_done       = done;
        nxt.drive_latch     = d;

        result.ext_relay        = d[uppc_pkg::D_EXT];
        result.bat_relay        = d[uppc_pkg::D_BAT];
        result.green_lamp       = d[uppc_pkg::D_GREEN];
        result.red_led          = d[uppc_pkg::D_RED];
        result.blue_lamp        = d[uppc_pkg::D_BLUE];
        result.buzzer_on        = d[uppc_pkg::D_BUZZ];
        result.unmount_request  = elo || ovp;
        result.shutdown_request = shut;
        result.ovp_flag         = ovp;
    end

endmodule

/* design/ups_power_path_controller.sv */
// Top level of the UPS power-path controller: APB registers, state and item handshake.
//
//   Channel   Direction  Handshake                 Payload
//   s_        in         s_valid / s_ready         s_data  (ADC samples of one tick)
//   m_        out        m_valid / m_ready         m_data  (drives and requests)
//   APB       in/out     psel, penable, pready     paddr, pwdata, prdata
//
// One item is accepted per cycle; its result is written to the output register at
// the accepting edge and offered on m_ in the following cycle. The rule logic and
// state update sit in one combinational pass between the accepted payload and the
// result register. s_ready stays high while the result register is empty or being
// taken, and drops while a held result waits on m_ready. aresetn resets the
// controller state and m_valid and reloads the default thresholds.
module ups_power_path_controller (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  uppc_pkg::in_item_t                   s_data,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output uppc_pkg::out_item_t                  m_data,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [uppc_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [uppc_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [uppc_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                 pready
);

    uppc_pkg::cfg_t        cfg_reg;
    uppc_pkg::ctrl_state_t state_reg;
    uppc_pkg::ctrl_state_t state_next;
    uppc_pkg::out_item_t   result_next;
    uppc_pkg::out_item_t   out_reg;
    logic                  out_valid_reg;
    logic                  accept;
    logic                  cfg_write;
    logic [uppc_pkg::REG_IDX_BITS-1:0] reg_idx;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign pready    = 1'b1;
    assign reg_idx   = paddr[uppc_pkg::PADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite;

    // Rule evaluation for the item being accepted.
    uppc_rules u_rules (
        .item   (s_data),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (result_next)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ovp_level      <= uppc_pkg::RST_OVP_LEVEL;
            cfg_reg.ext_high_level <= uppc_pkg::RST_EXT_HIGH;
            cfg_reg.ext_low_level  <= uppc_pkg::RST_EXT_LOW;
            cfg_reg.bat_high_level <= uppc_pkg::RST_BAT_HIGH;
            cfg_reg.bat_low_level  <= uppc_pkg::RST_BAT_LOW;
            cfg_reg.beep_length    <= uppc_pkg::RST_BEEP_LENGTH;
        end else if (cfg_write) begin
            case (reg_idx)
                uppc_pkg::REG_OVP_LEVEL: begin
                    cfg_reg.ovp_level <= pwdata[uppc_pkg::SAMPLE_BITS-1:0];
                end
                uppc_pkg::REG_EXT_HIGH: begin
                    cfg_reg.ext_high_level <= pwdata[uppc_pkg::SAMPLE_BITS-1:0];
                end
                uppc_pkg::REG_EXT_LOW: begin
                    cfg_reg.ext_low_level <= pwdata[uppc_pkg::SAMPLE_BITS-1:0];
                end
                uppc_pkg::REG_BAT_HIGH: begin
                    cfg_reg.bat_high_level <= pwdata[uppc_pkg::SAMPLE_BITS-1:0];
                end
                uppc_pkg::REG_BAT_LOW: begin
                    cfg_reg.bat_low_level <= pwdata[uppc_pkg::SAMPLE_BITS-1:0];
                end
                uppc_pkg::REG_BEEP_LENGTH: begin
                    cfg_reg.beep_length <= pwdata[uppc_pkg::BEEP_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            uppc_pkg::REG_OVP_LEVEL:   prdata = uppc_pkg::PDATA_BITS'(cfg_reg.ovp_level);
            uppc_pkg::REG_EXT_HIGH:    prdata = uppc_pkg::PDATA_BITS'(cfg_reg.ext_high_level);
            uppc_pkg::REG_EXT_LOW:     prdata = uppc_pkg::PDATA_BITS'(cfg_reg.ext_low_level);
            uppc_pkg::REG_BAT_HIGH:    prdata = uppc_pkg::PDATA_BITS'(cfg_reg.bat_high_level);
            uppc_pkg::REG_BAT_LOW:     prdata = uppc_pkg::PDATA_BITS'(cfg_reg.bat_low_level);
            uppc_pkg::REG_BEEP_LENGTH: prdata = uppc_pkg::PDATA_BITS'(cfg_reg.beep_length);
            default:                   prdata = '0;
        endcase
    end

    // Controller state advances once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.armed           <= 1'b0;
            state_reg.ovp_blink_count <= '0;
            state_reg.beep_countdown  <= uppc_pkg::RST_BEEP_LENGTH;
            state_reg.beep_done       <= 1'b0;
            state_reg.drive_latch     <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Result register and its valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result_next;
        end
    end

endmodule

/* sim/uppc_drive_checker.sv */
// Checker for the UPS power-path controller: predicts each tick's drives and compares results.
module uppc_drive_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  uppc_pkg::in_item_t                   s_data,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  uppc_pkg::out_item_t                  m_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [uppc_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [uppc_pkg::PDATA_BITS-1:0]      pwdata,
    output int                                   errors,
    output int                                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Thresholds as last written over the register port.
    logic [uppc_pkg::SAMPLE_BITS-1:0] lvl_ovp;
    logic [uppc_pkg::SAMPLE_BITS-1:0] lvl_ext_hi;
    logic [uppc_pkg::SAMPLE_BITS-1:0] lvl_ext_lo;
    logic [uppc_pkg::SAMPLE_BITS-1:0] lvl_bat_hi;
    logic [uppc_pkg::SAMPLE_BITS-1:0] lvl_bat_lo;
    logic [uppc_pkg::BEEP_BITS-1:0]   beep_len;

    // Controller state as this checker tracks it.
    logic                             armed;
    logic [uppc_pkg::BLINK_BITS-1:0]  blink_cnt;
    logic [uppc_pkg::BEEP_BITS-1:0]   beep_cnt;
    logic                             beep_done;
    logic [uppc_pkg::DRIVE_BITS-1:0]  drives;

    // Drive results predicted for accepted ticks, oldest first.
    uppc_pkg::out_item_t              pending_drives[$];
    uppc_pkg::out_item_t              want;

    // Set the relays and the three LEDs; the buzzer keeps its state.
    function automatic void set_five(input logic e, input logic b, input logic g,
                                     input logic r, input logic bl);
        drives[uppc_pkg::D_EXT]   = e;
        drives[uppc_pkg::D_BAT]   = b;
        drives[uppc_pkg::D_GREEN] = g;
        drives[uppc_pkg::D_RED]   = r;
        drives[uppc_pkg::D_BLUE]  = bl;
    endfunction

    // Run one control tick against the tracked state and return the drives it leaves.
    function automatic uppc_pkg::out_item_t predict_tick(input uppc_pkg::in_item_t it);
        logic                ovp;
        logic                shut;
        logic                unmount;
        logic                bhi;
        logic                bmid;
        logic                blo;
        logic                ehi;
        logic                elo;
        logic                emid;
        uppc_pkg::out_item_t res;
        shut = 1'b0;
        bhi  = it.bat_sample > lvl_bat_hi;
        bmid = it.bat_sample > lvl_bat_lo && it.bat_sample < lvl_bat_hi;
        blo  = it.bat_sample < lvl_bat_lo;
        ehi  = it.ext_sample > lvl_ext_hi;
        elo  = it.ext_sample < lvl_ext_lo;
        emid = it.ext_sample > lvl_ext_lo && it.ext_sample < lvl_ext_hi;

        // Over-voltage opens the external relay and blinks green from the counter.
        ovp = it.ext_sample > lvl_ovp;
        if (ovp) begin
            drives[uppc_pkg::D_EXT] = 1'b0;
            blink_cnt = blink_cnt + uppc_pkg::BLINK_BITS'(1);
            if (blink_cnt > uppc_pkg::BLINK_ON_START &&
                blink_cnt < uppc_pkg::BLINK_OFF_FROM) begin
                drives[uppc_pkg::D_GREEN] = 1'b1;
            end else if (blink_cnt >= uppc_pkg::BLINK_OFF_FROM) begin
                drives[uppc_pkg::D_GREEN] = 1'b0;
            end
        end
        if (blink_cnt == uppc_pkg::BLINK_WRAP) begin
            blink_cnt = '0;
        end
        unmount = elo || ovp;

        // External supply high, or over-voltage.
        if (ehi && bhi && !ovp) begin
            armed = 1'b1;
            set_five(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        end else if (ehi && bmid && !ovp) begin
            armed = 1'b1;
            set_five(1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        end else if (ehi && blo && !ovp) begin
            armed = 1'b1;
            set_five(1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        end else if (bhi && ovp) begin
            armed = 1'b1;
            drives[uppc_pkg::D_BAT]  = 1'b1;
            drives[uppc_pkg::D_RED]  = 1'b0;
            drives[uppc_pkg::D_BLUE] = 1'b0;
        end else if (bmid && ovp) begin
            armed = 1'b1;
            drives[uppc_pkg::D_BAT]  = 1'b1;
            drives[uppc_pkg::D_RED]  = 1'b0;
            drives[uppc_pkg::D_BLUE] = 1'b1;
        end else if (blo && ovp) begin
            drives[uppc_pkg::D_RED]  = 1'b1;
            drives[uppc_pkg::D_BLUE] = 1'b0;
            if (armed) begin
                drives = '0;
                armed  = 1'b0;
                shut   = 1'b1;
            end
        end

        // External supply in the middle band.
        if (emid && bhi) begin
            armed = 1'b1;
            set_five(1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        end else if (emid && bmid) begin
            armed = 1'b1;
            set_five(1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        end else if (emid && blo) begin
            armed = 1'b1;
            set_five(1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        end

        // External supply low while disarmed.
        if (elo && !armed) begin
            if (bhi) begin
                armed = 1'b1;
                set_five(1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
            end else if (bmid) begin
                set_five(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
            end else if (blo) begin
                set_five(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            end
        end

        // One-shot mains-loss beep; a returning supply does not reload the countdown.
        if (elo && it.bat_sample > lvl_bat_lo && !beep_done) begin
            if (beep_cnt == beep_len) begin
                drives[uppc_pkg::D_BUZZ] = 1'b1;
            end
            if (beep_cnt == '0) begin
                drives[uppc_pkg::D_BUZZ] = 1'b0;
                beep_cnt  = beep_len;
                beep_done = 1'b1;
            end else begin
                beep_cnt = beep_cnt - uppc_pkg::BEEP_BITS'(1);
            end
        end else if (ehi) begin
            beep_done                = 1'b0;
            drives[uppc_pkg::D_BUZZ] = 1'b0;
        end

        // External supply low while armed; a confirmed low battery shuts down.
        if (elo && armed) begin
            if (bhi) begin
                set_five(1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
            end else if (bmid) begin
                set_five(1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
            end else if (blo) begin
                if (it.bat_recheck < lvl_bat_lo) begin
                    drives = '0;
                    armed  = 1'b0;
                    shut   = 1'b1;
                end
            end
        end

        res.ext_relay        = drives[uppc_pkg::D_EXT];
        res.bat_relay        = drives[uppc_pkg::D_BAT];
        res.green_lamp       = drives[uppc_pkg::D_GREEN];
        res.red_led          = drives[uppc_pkg::D_RED];
        res.blue_lamp        = drives[uppc_pkg::D_BLUE];
        res.buzzer_on        = drives[uppc_pkg::D_BUZZ];
        res.unmount_request  = unmount;
        res.shutdown_request = shut;
        res.ovp_flag         = ovp;
        return res;
    endfunction

    function automatic string field_name(input int k);
        case (k)
            8:       return "ext_relay";
            7:       return "bat_relay";
            6:       return "green_lamp";
            5:       return "red_led";
            4:       return "blue_lamp";
            3:       return "buzzer_on";
            2:       return "unmount_request";
            1:       return "shutdown_request";
            default: return "ovp_flag";
        endcase
    endfunction

    // Compare results first, then predict the new item, then track register writes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            lvl_ovp    = uppc_pkg::RST_OVP_LEVEL;
            lvl_ext_hi = uppc_pkg::RST_EXT_HIGH;
            lvl_ext_lo = uppc_pkg::RST_EXT_LOW;
            lvl_bat_hi = uppc_pkg::RST_BAT_HIGH;
            lvl_bat_lo = uppc_pkg::RST_BAT_LOW;
            beep_len   = uppc_pkg::RST_BEEP_LENGTH;
            armed      = 1'b0;
            blink_cnt  = '0;
            beep_cnt   = uppc_pkg::RST_BEEP_LENGTH;
            beep_done  = 1'b0;
            drives     = '0;
            pending_drives.delete();
            pending    <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_drives.size() == 0) begin
                    $display("%0t ns: result item with none expected, got %b", $time, m_data);
                    errors = errors + 1;
                end else begin
                    want = pending_drives.pop_front();
                    for (int k = $bits(uppc_pkg::out_item_t) - 1; k >= 0; k--) begin
                        if (want[k] !== m_data[k]) begin
                            $display("%0t ns: %s expected %0b, got %0b",
                                     $time, field_name(k), want[k], m_data[k]);
                            errors = errors + 1;
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_drives.push_back(predict_tick(s_data));
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[uppc_pkg::PADDR_BITS-1:2])
                    uppc_pkg::REG_OVP_LEVEL:   lvl_ovp    = pwdata[uppc_pkg::SAMPLE_BITS-1:0];
                    uppc_pkg::REG_EXT_HIGH:    lvl_ext_hi = pwdata[uppc_pkg::SAMPLE_BITS-1:0];
                    uppc_pkg::REG_EXT_LOW:     lvl_ext_lo = pwdata[uppc_pkg::SAMPLE_BITS-1:0];
                    uppc_pkg::REG_BAT_HIGH:    lvl_bat_hi = pwdata[uppc_pkg::SAMPLE_BITS-1:0];
                    uppc_pkg::REG_BAT_LOW:     lvl_bat_lo = pwdata[uppc_pkg::SAMPLE_BITS-1:0];
                    uppc_pkg::REG_BEEP_LENGTH: beep_len   = pwdata[uppc_pkg::BEEP_BITS-1:0];
                    default: ;
                endcase
            end
            pending <= pending_drives.size();
        end
    end

endmodule

/* sim/tb_ups_power_path_controller.sv */
// Testbench top for the UPS power-path controller: clock, reset, stimulus and verdict.
module tb_ups_power_path_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int SAMPLE_MAX = (1 << uppc_pkg::SAMPLE_BITS) - 1;

    // Sample bands that a run of ticks stays in.
    typedef enum int {BAND_OVP, BAND_HIGH, BAND_MID, BAND_LOW, BAND_EDGE, BAND_NOISE} band_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    uppc_pkg::in_item_t                  s_data = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    uppc_pkg::out_item_t                 m_data;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [uppc_pkg::PADDR_BITS-1:0]     paddr = '0;
    logic [uppc_pkg::PDATA_BITS-1:0]     pwdata = '0;
    logic [uppc_pkg::PDATA_BITS-1:0]     prdata;
    logic                                pready;

    int                                  errors;
    int                                  pending;
    int                                  idle_cycles = 0;
    logic                                calm = 1'b0;

    // Thresholds currently programmed, used to aim the stimulus.
    int lv_ovl = int'(uppc_pkg::RST_OVP_LEVEL);
    int lv_ehl = int'(uppc_pkg::RST_EXT_HIGH);
    int lv_ell = int'(uppc_pkg::RST_EXT_LOW);
    int lv_bhl = int'(uppc_pkg::RST_BAT_HIGH);
    int lv_bll = int'(uppc_pkg::RST_BAT_LOW);

    always #5 aclk = ~aclk;

    ups_power_path_controller dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    uppc_drive_checker u_checker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .errors  (errors),
        .pending (pending)
    );

    // Result side stalls about one cycle in ten, except during the calm stretch.
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99, 0) >= 10);
    end

    // Give up when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int rand_in(input int lo, input int hi);
        if (lo > hi) begin
            return int'($urandom_range(SAMPLE_MAX, 0));
        end
        return int'($urandom_range(hi, lo));
    endfunction

    // A threshold or one of its neighbors.
    function automatic int near(input int t);
        int v;
        v = t - 1 + int'($urandom_range(2, 0));
        if (v < 0) begin
            v = 0;
        end else if (v > SAMPLE_MAX) begin
            v = SAMPLE_MAX;
        end
        return v;
    endfunction

    function automatic band_t pick_ext_band();
        int k;
        k = $urandom_range(99, 0);
        if (k < 20) return BAND_OVP;
        if (k < 40) return BAND_HIGH;
        if (k < 55) return BAND_MID;
        if (k < 85) return BAND_LOW;
        if (k < 93) return BAND_EDGE;
        return BAND_NOISE;
    endfunction

    function automatic band_t pick_bat_band();
        int k;
        k = $urandom_range(99, 0);
        if (k < 30) return BAND_HIGH;
        if (k < 60) return BAND_MID;
        if (k < 85) return BAND_LOW;
        if (k < 93) return BAND_EDGE;
        return BAND_NOISE;
    endfunction

    function automatic int ext_value(input band_t bd);
        int k;
        case (bd)
            BAND_OVP:  return rand_in(lv_ovl + 1, SAMPLE_MAX);
            BAND_HIGH: return rand_in(lv_ehl + 1, lv_ovl);
            BAND_MID:  return rand_in(lv_ell + 1, lv_ehl - 1);
            BAND_LOW:  return rand_in(0, lv_ell - 1);
            BAND_EDGE: begin
                k = $urandom_range(2, 0);
                return near(k == 0 ? lv_ovl : (k == 1 ? lv_ehl : lv_ell));
            end
            default:   return int'($urandom_range(SAMPLE_MAX, 0));
        endcase
    endfunction

    function automatic int bat_value(input band_t bd);
        case (bd)
            BAND_HIGH: return rand_in(lv_bhl + 1, SAMPLE_MAX);
            BAND_MID:  return rand_in(lv_bll + 1, lv_bhl - 1);
            BAND_LOW:  return rand_in(0, lv_bll - 1);
            BAND_EDGE: return near($urandom_range(1, 0) ? lv_bhl : lv_bll);
            default:   return int'($urandom_range(SAMPLE_MAX, 0));
        endcase
    endfunction

    // Recheck mostly confirms a low battery, sometimes sits at the threshold.
    function automatic int recheck_value();
        int k;
        k = $urandom_range(99, 0);
        if (k < 50) return rand_in(0, lv_bll - 1);
        if (k < 70) return near(lv_bll);
        return int'($urandom_range(SAMPLE_MAX, 0));
    endfunction

    // Offer one tick, with an occasional gap first, and hold it until taken.
    task automatic send_tick(input int e, input int b, input int r);
        int                 gap;
        uppc_pkg::in_item_t it;
        gap = 0;
        if (!calm && $urandom_range(99, 0) < 5) begin
            gap = $urandom_range(3, 1);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        it.ext_sample  = uppc_pkg::SAMPLE_BITS'(e);
        it.bat_sample  = uppc_pkg::SAMPLE_BITS'(b);
        it.bat_recheck = uppc_pkg::SAMPLE_BITS'(r);
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Runs of ticks that hold a supply condition long enough to reach the beep,
    // the blink wrap and shutdowns, mixed with runs of pure noise.
    task automatic run_random(input int n_items);
        int    left;
        int    len;
        int    k;
        logic  noise;
        band_t eb;
        band_t bb;
        left = n_items;
        while (left > 0) begin
            k = $urandom_range(99, 0);
            if (k < 70) begin
                len = $urandom_range(12, 1);
            end else if (k < 95) begin
                len = $urandom_range(60, 13);
            end else begin
                len = $urandom_range(120, 61);
            end
            if (len > left) begin
                len = left;
            end
            noise = ($urandom_range(99, 0) < 12);
            eb = pick_ext_band();
            bb = pick_bat_band();
            repeat (len) begin
                if (noise) begin
                    send_tick($urandom_range(SAMPLE_MAX, 0), $urandom_range(SAMPLE_MAX, 0),
                              $urandom_range(SAMPLE_MAX, 0));
                end else begin
                    send_tick(ext_value(eb), bat_value(bb), recheck_value());
                end
            end
            left = left - len;
        end
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic cfg_write(input logic [uppc_pkg::REG_IDX_BITS-1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= uppc_pkg::PDATA_BITS'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            uppc_pkg::REG_OVP_LEVEL: lv_ovl = value;
            uppc_pkg::REG_EXT_HIGH:  lv_ehl = value;
            uppc_pkg::REG_EXT_LOW:   lv_ell = value;
            uppc_pkg::REG_BAT_HIGH:  lv_bhl = value;
            uppc_pkg::REG_BAT_LOW:   lv_bll = value;
            default: ;
        endcase
    endtask

    // Drain all results, then reprogram every register.
    task automatic apply_config(input int ovl, input int ehl, input int ell,
                                input int bhl, input int bll, input int blen);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        cfg_write(uppc_pkg::REG_OVP_LEVEL, ovl);
        cfg_write(uppc_pkg::REG_EXT_HIGH, ehl);
        cfg_write(uppc_pkg::REG_EXT_LOW, ell);
        cfg_write(uppc_pkg::REG_BAT_HIGH, bhl);
        cfg_write(uppc_pkg::REG_BAT_LOW, bll);
        cfg_write(uppc_pkg::REG_BEEP_LENGTH, blen);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int ell;
        int ehl;
        int bll;
        int bhl;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks at the reset thresholds.
        send_tick(0, 0, 0);                 // all low while disarmed: everything off
        send_tick(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        send_tick(820, 755, 692);           // values equal to thresholds match nothing
        send_tick(755, 692, 0);
        send_tick(900, 800, 0);             // at the over-voltage level, not above it
        send_tick(901, 700, 0);             // over-voltage with battery mid
        send_tick(901, 600, 0);             // over-voltage with battery low while armed
        send_tick(800, 800, 0);
        send_tick(800, 700, 0);
        send_tick(800, 600, 0);
        send_tick(850, 700, 0);
        send_tick(850, 600, 0);
        send_tick(100, 800, 0);             // mains lost while armed: beep starts
        send_tick(100, 700, 0);
        send_tick(100, 600, 700);           // low battery not confirmed by recheck
        send_tick(100, 600, 692);
        send_tick(100, 600, 691);           // confirmed low battery: shutdown
        send_tick(100, 700, 0);
        send_tick(100, 800, 0);
        send_tick(SAMPLE_MAX, 0, SAMPLE_MAX);
        send_tick(0, SAMPLE_MAX, 0);
        send_tick(10'h2AA, 10'h155, 10'h2AA);
        send_tick(10'h155, 10'h2AA, 10'h155);
        run_random(380);

        // Ordered thresholds, with no stalls on either side.
        ell = $urandom_range(700, 200);
        ehl = ell + $urandom_range(150, 1);
        bll = $urandom_range(700, 100);
        bhl = bll + $urandom_range(200, 1);
        apply_config(ehl + $urandom_range(SAMPLE_MAX - ehl, 1), ehl, ell, bhl, bll,
                     $urandom_range(63, 1));
        calm <= 1'b1;
        run_random(300);
        calm <= 1'b0;

        // Extremes of every threshold register, with beep lengths of 1 and 63.
        apply_config(0, 0, 0, 0, 0, 1);
        run_random(150);
        apply_config(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 63);
        run_random(150);

        // Crossed thresholds: low levels above high levels.
        ell = $urandom_range(1000, 600);
        bll = $urandom_range(1000, 500);
        apply_config($urandom_range(SAMPLE_MAX, 0), $urandom_range(ell - 1, 100), ell,
                     $urandom_range(bll - 1, 50), bll, $urandom_range(63, 1));
        run_random(200);

        // A zero beep length beeps on and off within one tick.
        ell = $urandom_range(700, 200);
        ehl = ell + $urandom_range(150, 1);
        bll = $urandom_range(700, 100);
        bhl = bll + $urandom_range(200, 1);
        apply_config(ehl + $urandom_range(SAMPLE_MAX - ehl, 1), ehl, ell, bhl, bll, 0);
        run_random(200);

        // Short beeps so several mains-loss cycles complete.
        ell = $urandom_range(700, 200);
        ehl = ell + $urandom_range(150, 1);
        bll = $urandom_range(700, 100);
        bhl = bll + $urandom_range(200, 1);
        apply_config(ehl + $urandom_range(SAMPLE_MAX - ehl, 1), ehl, ell, bhl, bll,
                     $urandom_range(8, 1));
        run_random(300);

        // Wait for the last results, then wait on for any stray item.
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
